### src/bitmap_slot_allocator_assert.svh
// Assertion macros used by the checker of the slot allocator.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define BSA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define BSA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bsa_pkg.sv
package bsa_pkg;

	// Used-map word geometry.
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned BIT_W = 5;
	localparam int unsigned ID_W = 11;
	localparam int unsigned WPART_W = ID_W - BIT_W;
	localparam logic [31:0] FULL_WORD = 32'hffffffff;

	// Register reset value.
	localparam logic [5:0] WIU_RESET = 6'd32;

	// Operation codes.
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD_ID = 2'd2;

	typedef struct packed {
		logic func;
		logic [10:0] free_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [10:0] slot_id;
		logic word_opened;
		logic word_emptied;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take;
		logic lookup;
		logic update;
		logic reject;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic go;
		logic slot_free;
	} sts_t;

endpackage

### src/bsa_ram.sv
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/bsa_ctrl.sv
module bsa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bsa_pkg::sts_t sts,
	output bsa_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Sequencing: take a word, look up the map word, then update or reject.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = sts.go ? S_UPDATE : S_FINISH;
			end
			S_UPDATE: begin
				if (sts.slot_free) begin
					cmd.update = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FINISH: begin
				if (sts.slot_free) begin
					cmd.reject = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/bsa_datapath.sv
module bsa_datapath #(
	parameter int MAP_WORDS = 32
) (
	input logic clk,
	input logic arst_n,
	input bsa_pkg::req_t in_word,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	input bsa_pkg::cmd_t cmd,
	output bsa_pkg::sts_t sts,
	input logic out_ready,
	output logic out_valid,
	output bsa_pkg::rsp_t out_word
);

	localparam int IW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	bsa_pkg::req_t req_q;
	bsa_pkg::rsp_t rsp_q;
	logic out_valid_q;
	logic [5:0] wiu_q;
	logic [IW-1:0] idx_q;
	logic live_q;
	logic [MAP_WORDS-1:0] valid_q;
	logic [MAP_WORDS-1:0] full_q;

	logic found;
	logic [IW-1:0] hit_idx;
	logic [5:0] wpart;
	logic id_ok;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] lk_idx;
	logic [31:0] rd_data;
	logic [31:0] cur;
	logic [4:0] low_b;
	logic [4:0] free_b;
	logic [31:0] new_word;
	logic [6:0] wnum;
	logic is_alloc;

	assign is_alloc = (req_q.func == bsa_pkg::FUNC_ALLOC);

	// First word that is not full among the words searched.
	always_comb begin
		found = 1'b0;
		hit_idx = '0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i] && (7'(i) < {1'b0, wiu_q})) begin
				found = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	// Word part of a freed identifier and its range check.
	assign wpart = req_q.free_id[10:5];
	assign id_ok = (wpart != 6'd0) && ({1'b0, wpart} <= 7'(MAP_WORDS));
	assign free_idx = IW'(wpart - 6'd1);
	assign lk_idx = is_alloc ? hit_idx : free_idx;

	assign sts.go = is_alloc ? found : id_ok;
	assign sts.slot_free = !out_valid_q || out_ready;

	// A word never written since reset reads as empty.
	assign cur = live_q ? rd_data : '0;

	// Lowest clear bit of the current word.
	always_comb begin
		low_b = '0;
		for (int k = 31; k >= 0; k--) begin
			if (!cur[k]) begin
				low_b = 5'(k);
			end
		end
	end

	assign free_b = req_q.free_id[4:0];
	assign new_word = is_alloc ? (cur | (32'd1 << low_b)) : (cur & ~(32'd1 << free_b));
	assign wnum = 7'(idx_q) + 7'd1;

	bsa_ram #(
		.WIDTH(32),
		.DEPTH(MAP_WORDS),
		.ADDR_W(IW)
	) u_map (
		.clk(clk),
		.wr_en(cmd.update),
		.wr_addr(idx_q),
		.wr_data(new_word),
		.rd_en(cmd.lookup && sts.go),
		.rd_addr(lk_idx),
		.rd_data(rd_data)
	);

	// Request, lookup and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= in_word;
		end
		if (cmd.lookup && sts.go) begin
			idx_q <= lk_idx;
			live_q <= valid_q[lk_idx];
		end
		if (cmd.update) begin
			rsp_q.status <= bsa_pkg::ST_OK;
			rsp_q.slot_id <= is_alloc ? {wnum[5:0], low_b} : '0;
			rsp_q.word_opened <= is_alloc && (cur == '0);
			rsp_q.word_emptied <= !is_alloc && (cur != '0) && (new_word == '0);
		end else if (cmd.reject) begin
			rsp_q.status <= is_alloc ? bsa_pkg::ST_FULL : bsa_pkg::ST_BAD_ID;
			rsp_q.slot_id <= '0;
			rsp_q.word_opened <= 1'b0;
			rsp_q.word_emptied <= 1'b0;
		end
	end

	// Control state: register, word flags and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= bsa_pkg::WIU_RESET;
			valid_q <= '0;
			full_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wiu_q <= cfg_wdata;
			end
			if (cmd.update) begin
				valid_q[idx_q] <= 1'b1;
				full_q[idx_q] <= (new_word == bsa_pkg::FULL_WORD);
			end
			if (cmd.update || cmd.reject) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = rsp_q;

endmodule

### src/bitmap_slot_allocator.sv
// Bitmap slot allocator. An allocate word takes the lowest free bit of the first used-map
// word that is not full, among the first words_in_use words (set through cfg_wdata, 32
// after reset), and returns ((word+1)<<5)|bit; a free word clears the named bit. The block
// works on one word at a time: an accepted word goes through a lookup step and then an
// update or reject step, which registers and offers the result; the block is ready for
// the next word while that result is offered. A stalled output holds the block in its
// update or reject step until the waiting result is taken. These steps follow from the
// read-modify-write of the used-map RAM, which has one registered read port. Per-word valid
// and full flags live in flip-flops that reset clears, so the map is usable right after
// reset with no clearing pass. The register may be written only while the block is idle.
module bitmap_slot_allocator #(
	parameter int MAP_WORDS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bsa_pkg::req_t in_word,
	output logic out_valid,
	input logic out_ready,
	output bsa_pkg::rsp_t out_word,
	input logic cfg_we,
	input logic [5:0] cfg_wdata
);

	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	bsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	bsa_datapath #(
		.MAP_WORDS(MAP_WORDS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_word(in_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.sts(sts),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_word(out_word)
	);

endmodule

### src/bitmap_slot_allocator_checker.sv
`include "bitmap_slot_allocator_assert.svh"

module bitmap_slot_allocator_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input bsa_pkg::rsp_t out_word
);

	logic rsp_clean;
	logic open_ok;

	// A result with no identifier and no flags.
	assign rsp_clean = (out_word.slot_id == 11'd0) && !out_word.word_opened &&
		!out_word.word_emptied;

	// An opened word hands out bit zero of a real word and empties nothing.
	assign open_ok = (out_word.slot_id[4:0] == 5'd0) && !out_word.word_emptied &&
		(out_word.slot_id[10:5] != 6'd0);

	// A waiting result stays offered.
	`BSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

	// A waiting result keeps its payload.
	`BSA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word), "result changed")

	// A refused request carries no identifier and no flags.
	`BSA_ASSERT_NOW(a_reject_clean, out_valid && (out_word.status != bsa_pkg::ST_OK), rsp_clean, "refused result has payload")

	// Opening a word always hands out its bit zero and never empties a word.
	`BSA_ASSERT_NOW(a_open_bit0, out_valid && out_word.word_opened, open_ok, "opened word did not give bit zero")

endmodule

bind bitmap_slot_allocator bitmap_slot_allocator_checker u_checker (.*);

### tb/sv/bitmap_slot_allocator_tb.sv
module bitmap_slot_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_WORDS = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bsa_pkg::req_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bsa_pkg::rsp_t out_word;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	// Shadow of the allocator state, updated as each request word is accepted.
	logic [31:0] slot_map_shadow [MAP_WORDS];
	logic [5:0] search_words = bsa_pkg::WIU_RESET;

	// Request words waiting to be offered and result words still owed by the block.
	bsa_pkg::req_t slot_requests_queued [$];
	bsa_pkg::rsp_t slot_results_due [$];
	int unsigned mismatch_count = 0;

	// Sender pacing and receiver stall state.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_clock = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 1000;
	logic [15:0] ready_pattern = 16'hffff;

	bitmap_slot_allocator #(
		.MAP_WORDS(MAP_WORDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Computes the result of one request word and applies it to the shadow map.
	function automatic bsa_pkg::rsp_t predict_slot_result(bsa_pkg::req_t req);
		bsa_pkg::rsp_t res;
		int unsigned limit;
		int unsigned b;
		logic [bsa_pkg::WPART_W-1:0] wpart;
		logic [31:0] prior;
		logic [31:0] after;
		res = '0;
		if (req.func == bsa_pkg::FUNC_ALLOC) begin
			limit = (search_words > MAP_WORDS) ? MAP_WORDS : search_words;
			res.status = bsa_pkg::ST_FULL;
			for (int unsigned w = 0; w < limit; w++) begin
				if (slot_map_shadow[w] != bsa_pkg::FULL_WORD) begin
					b = 0;
					while (slot_map_shadow[w][b])
						b++;
					res.status = bsa_pkg::ST_OK;
					res.slot_id = bsa_pkg::ID_W'(((w + 1) << bsa_pkg::BIT_W) | b);
					res.word_opened = (slot_map_shadow[w] == '0);
					slot_map_shadow[w][b] = 1'b1;
					break;
				end
			end
		end else begin
			wpart = req.free_id[bsa_pkg::ID_W-1:bsa_pkg::BIT_W];
			if (wpart == 0 || wpart > MAP_WORDS) begin
				res.status = bsa_pkg::ST_BAD_ID;
			end else begin
				prior = slot_map_shadow[wpart - 1];
				after = prior & ~(32'd1 << req.free_id[bsa_pkg::BIT_W-1:0]);
				slot_map_shadow[wpart - 1] = after;
				res.status = bsa_pkg::ST_OK;
				res.word_emptied = (prior != '0) && (after == '0);
			end
		end
		return res;
	endfunction

	// Formats the fields of one result word.
	function automatic string rsp_text(bsa_pkg::rsp_t word);
		return $sformatf("status=%0d id=%0d opened=%0b emptied=%0b", word.status,
			word.slot_id, word.word_opened, word.word_emptied);
	endfunction

	task automatic note_mismatch(input string what, input bsa_pkg::rsp_t exp_word,
		input bsa_pkg::rsp_t got_word);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected %s, got %s", $realtime, what, rsp_text(exp_word),
				rsp_text(got_word));
	endtask

	task automatic push_request(input logic func, input logic [10:0] id);
		bsa_pkg::req_t req;
		req.func = func;
		req.free_id = id;
		slot_requests_queued.push_back(req);
	endtask

	// Waits until every queued word has been sent and every result has come back.
	task automatic wait_idle();
		while (slot_requests_queued.size() != 0 || in_valid || slot_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_search_words(input logic [5:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		search_words = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting of the search window followed by a random mix of allocates and frees.
	task automatic run_random_phase(input logic [5:0] wiu, input int unsigned count,
		input int unsigned alloc_pct);
		int unsigned span;
		int unsigned sel;
		logic [10:0] id;
		wait_idle();
		write_search_words(wiu);
		span = (wiu > MAP_WORDS) ? MAP_WORDS : wiu;
		if (span == 0)
			span = 2;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(1, 100) <= alloc_pct) begin
				push_request(bsa_pkg::FUNC_ALLOC, 11'($urandom));
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 7)
					id = 11'((($urandom_range(0, span - 1) + 1) << bsa_pkg::BIT_W) |
						$urandom_range(0, 31));
				else if (sel == 7)
					id = 11'((($urandom_range(0, MAP_WORDS - 1) + 1) << bsa_pkg::BIT_W) |
						$urandom_range(0, 31));
				else if (sel == 8)
					id = {($urandom_range(0, 1) == 0) ? bsa_pkg::WPART_W'(0) :
						bsa_pkg::WPART_W'($urandom_range(33, 63)),
						bsa_pkg::BIT_W'($urandom_range(0, 31))};
				else
					id = 11'($urandom_range(0, 2047));
				push_request(bsa_pkg::FUNC_FREE, id);
			end
		end
	endtask

	// Sender: offers queued words in bursts separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (slot_requests_queued.size() != 0) begin
				in_word <= slot_requests_queued.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rotates a stall pattern and now and then holds off for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_clock++;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_clock == next_hold_at) begin
				hold_left = $urandom_range(150, 400);
				next_hold_at = stall_clock + $urandom_range(1500, 4000);
				out_ready <= 1'b0;
			end else begin
				if (stall_clock[5:0] == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pattern = 16'hffff;
						1: ready_pattern = 16'h0101;
						default: ready_pattern = 16'($urandom) | 16'h8000;
					endcase
				end
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
				out_ready <= ready_pattern[0];
			end
		end
	end

	// Predicts on each accepted request word and checks each accepted result word.
	always @(posedge clk) begin
		bsa_pkg::rsp_t due;
		if (arst_n) begin
			if (in_valid && in_ready)
				slot_results_due.push_back(predict_slot_result(in_word));
			if (out_valid && out_ready) begin
				if (slot_results_due.size() == 0) begin
					note_mismatch("result word with none due", '0, out_word);
				end else begin
					due = slot_results_due.pop_front();
					if (out_word.status !== due.status || out_word.slot_id !== due.slot_id ||
						out_word.word_opened !== due.word_opened ||
						out_word.word_emptied !== due.word_emptied)
						note_mismatch("result word differs", due, out_word);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAP_WORDS; i++)
			slot_map_shadow[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Invalid identifiers, a free of the last valid slot, and open/empty transitions.
		push_request(bsa_pkg::FUNC_FREE, 11'd0);
		push_request(bsa_pkg::FUNC_FREE, 11'd31);
		push_request(bsa_pkg::FUNC_FREE, 11'd1055);
		push_request(bsa_pkg::FUNC_FREE, 11'd2047);
		push_request(bsa_pkg::FUNC_FREE, 11'd1056);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);
		push_request(bsa_pkg::FUNC_FREE, 11'd32);
		push_request(bsa_pkg::FUNC_FREE, 11'd32);
		push_request(bsa_pkg::FUNC_ALLOC, 11'h555);
		push_request(bsa_pkg::FUNC_FREE, 11'd32);
		push_request(bsa_pkg::FUNC_FREE, 11'd33);
		push_request(bsa_pkg::FUNC_FREE, 11'd33);
		push_request(bsa_pkg::FUNC_ALLOC, 11'h7ff);

		// An empty search window, and a free outside the window.
		wait_idle();
		write_search_words(6'd0);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);
		push_request(bsa_pkg::FUNC_FREE, 11'd32);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);

		// A window wider than the map saturates.
		wait_idle();
		write_search_words(6'd63);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);
		push_request(bsa_pkg::FUNC_ALLOC, 11'd0);

		run_random_phase(6'd1, 110, 75);
		run_random_phase(6'd0, 60, 50);
		run_random_phase(6'd63, 110, 60);
		run_random_phase(6'd32, 150, 90);
		for (int p = 0; p < 8; p++)
			run_random_phase(($urandom_range(0, 3) == 0) ? 6'($urandom_range(33, 63)) :
				6'($urandom_range(1, 6)), 100, $urandom_range(35, 90));

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && slot_results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
